// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

	typedef enum logic [2:0] {
		PH_RG  = 3'd0,
		PH_RA  = 3'd1,
		PH_GR  = 3'd2,
		PH_AR  = 3'd3,
		PH_RR1 = 3'd4,
		PH_RR2 = 3'd5
	} phase_t;

	typedef struct packed {
		logic rush_hour;
		logic show_east_west;
	} tick_word_t;

	typedef struct packed {
		logic       red_lamp;
		logic       amber_lamp;
		logic       green_lamp;
		logic [2:0] phase_now;
	} lamp_word_t;

	typedef struct packed {
		logic [15:0] green_ticks_normal;
		logic [15:0] green_ticks_rush;
		logic [15:0] amber_ticks;
		logic [15:0] all_red_ticks_rush;
	} cfg_t;

	localparam logic [1:0] REG_GREEN_NORMAL = 2'd0;
	localparam logic [1:0] REG_GREEN_RUSH   = 2'd1;
	localparam logic [1:0] REG_AMBER        = 2'd2;
	localparam logic [1:0] REG_ALL_RED_RUSH = 2'd3;

	localparam logic [15:0] GREEN_NORMAL_RST = 16'd10000;
	localparam logic [15:0] GREEN_RUSH_RST   = 16'd30000;
	localparam logic [15:0] AMBER_RST        = 16'd3000;
	localparam logic [15:0] ALL_RED_RUSH_RST = 16'd1000;

endpackage

// ===== rtl/tsc_core.sv =====
module tsc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tsc_pkg::tick_word_t tick,
	input  tsc_pkg::cfg_t     cfg,
	output tsc_pkg::lamp_word_t word
);

	tsc_pkg::phase_t phase_q;
	tsc_pkg::phase_t phase_nxt;
	logic [15:0]     ticks_q;
	logic            rush_q;
	logic            started_q;

	logic            rush_eff;
	logic [15:0]     len;
	logic [15:0]     load_len;

	always_comb begin
		unique case (phase_q)
			tsc_pkg::PH_RG, tsc_pkg::PH_GR:
				load_len = tick.rush_hour ? cfg.green_ticks_rush : cfg.green_ticks_normal;
			tsc_pkg::PH_RA, tsc_pkg::PH_AR:
				load_len = cfg.amber_ticks;
			tsc_pkg::PH_RR1, tsc_pkg::PH_RR2:
				load_len = tick.rush_hour ? cfg.all_red_ticks_rush : 16'd0;
			default:
				load_len = 16'd0;
		endcase
	end

	// first tick of a phase samples the switch and loads the length
	assign rush_eff = started_q ? rush_q : tick.rush_hour;
	assign len      = started_q ? ticks_q : load_len;

	always_comb begin
		unique case (phase_q)
			tsc_pkg::PH_RG:  phase_nxt = tsc_pkg::PH_RA;
			tsc_pkg::PH_RA:  phase_nxt = rush_eff ? tsc_pkg::PH_RR1 : tsc_pkg::PH_GR;
			tsc_pkg::PH_GR:  phase_nxt = tsc_pkg::PH_AR;
			tsc_pkg::PH_AR:  phase_nxt = rush_eff ? tsc_pkg::PH_RR2 : tsc_pkg::PH_RG;
			tsc_pkg::PH_RR1: phase_nxt = tsc_pkg::PH_GR;
			default:         phase_nxt = tsc_pkg::PH_RG;
		endcase
	end

	always_comb begin
		word.red_lamp   = 1'b1;
		word.amber_lamp = 1'b0;
		word.green_lamp = 1'b0;
		word.phase_now  = phase_q;
		case (phase_q)
			tsc_pkg::PH_RG: begin
				word.red_lamp   = !tick.show_east_west;
				word.green_lamp = tick.show_east_west;
			end
			tsc_pkg::PH_RA: begin
				word.red_lamp   = !tick.show_east_west;
				word.amber_lamp = tick.show_east_west;
			end
			tsc_pkg::PH_GR: begin
				word.red_lamp   = tick.show_east_west;
				word.green_lamp = !tick.show_east_west;
			end
			tsc_pkg::PH_AR: begin
				word.red_lamp   = tick.show_east_west;
				word.amber_lamp = !tick.show_east_west;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tsc_pkg::PH_RG;
			ticks_q   <= 16'd0;
			rush_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (step) begin
			rush_q <= rush_eff;
			if (len <= 16'd1) begin
				phase_q   <= phase_nxt;
				started_q <= 1'b0;
				ticks_q   <= 16'd0;
			end else begin
				started_q <= 1'b1;
				ticks_q   <= len - 16'd1;
			end
		end
	end

	a_started_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> ticks_q != 16'd0)
		else $error("phase running with no ticks left");

	a_last_tick_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && started_q && ticks_q == 16'd1) |=> !started_q)
		else $error("phase did not end on its last tick");

	a_all_red_short: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !started_q && !tick.rush_hour &&
		 (phase_q == tsc_pkg::PH_RR1 || phase_q == tsc_pkg::PH_RR2))
		|=> (!started_q && phase_q != $past(phase_q)))
		else $error("all-red without rush lasted more than one tick");

endmodule

// ===== rtl/traffic_signal_controller.sv =====
// channel  direction  handshake               payload
// tick     in         tick_valid/tick_stall   tsc_pkg::tick_word_t
// lamp     out        lamp_valid/lamp_stall   tsc_pkg::lamp_word_t
// apb      in/out     psel/penable/pready     paddr, pwdata, prdata
//
// one tick word accepted per cycle unless stalled; its lamp word is registered
// the phase and tick counter update in the cycle a word is accepted
// a two-entry output (register plus skid) takes one more tick while lamp stalls
// tick_stall rises only once the skid entry is full
// reset returns phase RG, not started, and restores the register defaults
module traffic_signal_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  tsc_pkg::tick_word_t tick,
	output logic                lamp_valid,
	input  logic                lamp_stall,
	output tsc_pkg::lamp_word_t lamp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	tsc_pkg::cfg_t       cfg_q;
	tsc_pkg::lamp_word_t word;
	tsc_pkg::lamp_word_t out_q;
	tsc_pkg::lamp_word_t skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	logic                tick_acc;
	logic                lamp_take;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_ticks_normal <= tsc_pkg::GREEN_NORMAL_RST;
			cfg_q.green_ticks_rush   <= tsc_pkg::GREEN_RUSH_RST;
			cfg_q.amber_ticks        <= tsc_pkg::AMBER_RST;
			cfg_q.all_red_ticks_rush <= tsc_pkg::ALL_RED_RUSH_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				tsc_pkg::REG_GREEN_NORMAL: cfg_q.green_ticks_normal <= pwdata[15:0];
				tsc_pkg::REG_GREEN_RUSH:   cfg_q.green_ticks_rush   <= pwdata[15:0];
				tsc_pkg::REG_AMBER:        cfg_q.amber_ticks        <= pwdata[15:0];
				tsc_pkg::REG_ALL_RED_RUSH: cfg_q.all_red_ticks_rush <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tsc_pkg::REG_GREEN_NORMAL: prdata = {16'd0, cfg_q.green_ticks_normal};
			tsc_pkg::REG_GREEN_RUSH:   prdata = {16'd0, cfg_q.green_ticks_rush};
			tsc_pkg::REG_AMBER:        prdata = {16'd0, cfg_q.amber_ticks};
			tsc_pkg::REG_ALL_RED_RUSH: prdata = {16'd0, cfg_q.all_red_ticks_rush};
			default:                   prdata = 32'd0;
		endcase
	end

	assign tick_stall = skid_valid_q;
	assign tick_acc   = tick_valid && !tick_stall;
	assign lamp_take  = out_valid_q && !lamp_stall;

	tsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick_acc),
		.tick   (tick),
		.cfg    (cfg_q),
		.word   (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (lamp_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (tick_acc) begin
				if (out_valid_q && !lamp_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (lamp_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (lamp_take) begin
				out_q <= skid_q;
			end
		end else if (tick_acc) begin
			if (out_valid_q && !lamp_take) begin
				skid_q <= word;
			end else begin
				out_q <= word;
			end
		end
	end

	assign lamp_valid = out_valid_q;
	assign lamp       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with output register empty");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> lamp_valid)
		else $error("accepted tick word produced no lamp word");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && lamp_take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid word lost or repeated");

endmodule

// ===== tb/tb_traffic_signal_controller.sv =====
module tb_traffic_signal_controller;

	localparam int CYCLE_LIMIT = 100000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tick_valid = 1'b0;
	logic                tick_stall;
	tsc_pkg::tick_word_t tick = '0;
	logic                lamp_valid;
	logic                lamp_stall = 1'b0;
	tsc_pkg::lamp_word_t lamp;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	traffic_signal_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.lamp_valid(lamp_valid),
		.lamp_stall(lamp_stall),
		.lamp(lamp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	tsc_pkg::tick_word_t pending_ticks[$];
	tsc_pkg::lamp_word_t expected_lamps[$];

	int tick_gap_max = 12;
	int lamp_stall_max = 12;
	int ticks_sent = 0;
	int lamps_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int cycles = 0;
	logic rush_level = 1'b0;

	// controller state as predicted
	tsc_pkg::cfg_t     timing;
	tsc_pkg::phase_t   sig_phase = tsc_pkg::PH_RG;
	logic [15:0]       count_left = '0;
	logic              rush_held = 1'b0;
	logic              phase_live = 1'b0;

	initial begin
		timing.green_ticks_normal = tsc_pkg::GREEN_NORMAL_RST;
		timing.green_ticks_rush   = tsc_pkg::GREEN_RUSH_RST;
		timing.amber_ticks        = tsc_pkg::AMBER_RST;
		timing.all_red_ticks_rush = tsc_pkg::ALL_RED_RUSH_RST;
	end

	function automatic logic [15:0] phase_len(tsc_pkg::phase_t p, logic rush);
		case (p)
			tsc_pkg::PH_RG, tsc_pkg::PH_GR:
				phase_len = rush ? timing.green_ticks_rush : timing.green_ticks_normal;
			tsc_pkg::PH_RA, tsc_pkg::PH_AR:
				phase_len = timing.amber_ticks;
			tsc_pkg::PH_RR1, tsc_pkg::PH_RR2:
				phase_len = rush ? timing.all_red_ticks_rush : 16'd0;
			default: phase_len = 16'd0;
		endcase
	endfunction

	function automatic tsc_pkg::phase_t phase_after(tsc_pkg::phase_t p, logic rush);
		case (p)
			tsc_pkg::PH_RG:  phase_after = tsc_pkg::PH_RA;
			tsc_pkg::PH_RA:  phase_after = rush ? tsc_pkg::PH_RR1 : tsc_pkg::PH_GR;
			tsc_pkg::PH_GR:  phase_after = tsc_pkg::PH_AR;
			tsc_pkg::PH_AR:  phase_after = rush ? tsc_pkg::PH_RR2 : tsc_pkg::PH_RG;
			tsc_pkg::PH_RR1: phase_after = tsc_pkg::PH_GR;
			default:         phase_after = tsc_pkg::PH_RG;
		endcase
	endfunction

	function automatic tsc_pkg::lamp_word_t next_lamp_word(tsc_pkg::tick_word_t w);
		tsc_pkg::lamp_word_t lw;
		logic ew;
		ew = w.show_east_west;
		if (!phase_live) begin
			rush_held = w.rush_hour;
			count_left = phase_len(sig_phase, rush_held);
			phase_live = 1'b1;
		end
		lw = '0;
		lw.red_lamp = 1'b1;
		case (sig_phase)
			tsc_pkg::PH_RG: begin
				lw.red_lamp = !ew;
				lw.green_lamp = ew;
			end
			tsc_pkg::PH_RA: begin
				lw.red_lamp = !ew;
				lw.amber_lamp = ew;
			end
			tsc_pkg::PH_GR: begin
				lw.red_lamp = ew;
				lw.green_lamp = !ew;
			end
			tsc_pkg::PH_AR: begin
				lw.red_lamp = ew;
				lw.amber_lamp = !ew;
			end
			default: lw.red_lamp = 1'b1;
		endcase
		lw.phase_now = sig_phase;
		if (count_left <= 16'd1) begin
			sig_phase = phase_after(sig_phase, rush_held);
			phase_live = 1'b0;
			count_left = '0;
		end else begin
			count_left = count_left - 16'd1;
		end
		return lw;
	endfunction

	// driver
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else begin
			if (tick_valid && !tick_stall) begin
				expected_lamps.push_back(next_lamp_word(tick));
				ticks_sent++;
				gap_left = $urandom_range(0, tick_gap_max);
			end else if (!tick_valid && gap_left > 0) begin
				gap_left--;
			end
			if (!tick_valid || !tick_stall) begin
				if (gap_left == 0 && pending_ticks.size() > 0) begin
					tick <= pending_ticks.pop_front();
					tick_valid <= 1'b1;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		tsc_pkg::lamp_word_t exp_w;
		if (!arst_n) begin
			lamp_stall <= 1'b0;
		end else if (lamp_valid && !lamp_stall) begin
			if (expected_lamps.size() == 0) begin
				$error("lamp word with nothing expected: %h", lamp);
				mismatches++;
			end else begin
				exp_w = expected_lamps.pop_front();
				lamps_checked++;
				if (lamp.red_lamp !== exp_w.red_lamp) begin
					$error("red_lamp: expected %0d, got %0d", exp_w.red_lamp, lamp.red_lamp);
					mismatches++;
				end
				if (lamp.amber_lamp !== exp_w.amber_lamp) begin
					$error("amber_lamp: expected %0d, got %0d", exp_w.amber_lamp,
						lamp.amber_lamp);
					mismatches++;
				end
				if (lamp.green_lamp !== exp_w.green_lamp) begin
					$error("green_lamp: expected %0d, got %0d", exp_w.green_lamp,
						lamp.green_lamp);
					mismatches++;
				end
				if (lamp.phase_now !== exp_w.phase_now) begin
					$error("phase_now: expected %0d, got %0d", exp_w.phase_now, lamp.phase_now);
					mismatches++;
				end
			end
			stall_left = $urandom_range(0, lamp_stall_max);
			lamp_stall <= (stall_left != 0);
		end else if (lamp_stall) begin
			stall_left--;
			if (stall_left <= 0) lamp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reg_read_check(input logic [1:0] idx, input logic [15:0] expv);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[15:0] !== expv) begin
			$error("register %0d readback: expected %0d, got %0d", idx, expv, got[15:0]);
			mismatches++;
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tsc_pkg::REG_GREEN_NORMAL: timing.green_ticks_normal = val;
			tsc_pkg::REG_GREEN_RUSH:   timing.green_ticks_rush = val;
			tsc_pkg::REG_AMBER:        timing.amber_ticks = val;
			tsc_pkg::REG_ALL_RED_RUSH: timing.all_red_ticks_rush = val;
			default: ;
		endcase
		reg_read_check(idx, val);
	endtask

	task automatic set_timing(input logic [15:0] gn, gr, am, ar);
		reg_write(tsc_pkg::REG_GREEN_NORMAL, gn);
		reg_write(tsc_pkg::REG_GREEN_RUSH, gr);
		reg_write(tsc_pkg::REG_AMBER, am);
		reg_write(tsc_pkg::REG_ALL_RED_RUSH, ar);
		settings_used++;
	endtask

	// block is idle once every queued word has come back
	task automatic drain();
		@(negedge clk);
		while (pending_ticks.size() > 0 || tick_valid || expected_lamps.size() > 0)
			@(negedge clk);
	endtask

	// rush switch held as a level, flipped now and then; flip_pct 50 gives noise
	task automatic queue_random(input int n, input int flip_pct);
		tsc_pkg::tick_word_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < flip_pct) rush_level = ~rush_level;
			w.rush_hour = rush_level;
			w.show_east_west = 1'($urandom_range(0, 1));
			pending_ticks.push_back(w);
		end
	endtask

	initial begin
		tsc_pkg::tick_word_t w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		reg_read_check(tsc_pkg::REG_GREEN_NORMAL, tsc_pkg::GREEN_NORMAL_RST);
		reg_read_check(tsc_pkg::REG_GREEN_RUSH, tsc_pkg::GREEN_RUSH_RST);
		reg_read_check(tsc_pkg::REG_AMBER, tsc_pkg::AMBER_RST);
		reg_read_check(tsc_pkg::REG_ALL_RED_RUSH, tsc_pkg::ALL_RED_RUSH_RST);

		// short phases, zero all-red wait; rush toggles every four ticks, mid-phase too
		set_timing(16'd2, 16'd3, 16'd1, 16'd0);
		@(negedge clk);
		for (int i = 0; i < 24; i++) begin
			w.rush_hour = i[2];
			w.show_east_west = i[0];
			pending_ticks.push_back(w);
		end

		drain();
		set_timing(16'd4, 16'd6, 16'd2, 16'd3);
		queue_random(180, 12);

		// minimum lengths, no idling, rush noise
		drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd0);
		tick_gap_max = 0;
		lamp_stall_max = 0;
		queue_random(150, 50);

		// zero length in every register
		drain();
		set_timing(16'd0, 16'd0, 16'd0, 16'd0);
		tick_gap_max = 12;
		queue_random(120, 20);

		for (int k = 0; k < 3; k++) begin
			drain();
			set_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 5)), 16'($urandom_range(0, 4)));
			tick_gap_max = (k == 1) ? 0 : 12;
			lamp_stall_max = (k == 2) ? 0 : 12;
			queue_random(200, 8);
		end

		// full-scale rush lengths stay unused while the switch is off
		drain();
		set_timing(16'd3, 16'hFFFF, 16'd2, 16'hFFFF);
		tick_gap_max = 12;
		lamp_stall_max = 12;
		rush_level = 1'b0;
		queue_random(40, 0);

		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d timing settings, zero lengths and idle full-scale rush values",
			settings_used);
		$display("%0d tick words sent, %0d lamp words checked, %0d mismatches",
			ticks_sent, lamps_checked, mismatches);
		if (mismatches == 0 && expected_lamps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
